FILE: rtl/core/pod_pkg.sv
// Package with the payload types, state type, constants and arithmetic helpers of the pulse oscillator.
`timescale 1ns / 1ps

package pod_pkg;

  localparam int PHASE_FRAC_BITS = 24;
  localparam int SAMPLE_BITS     = 16;
  localparam int STEP_W          = 25;
  localparam int WIDTH_W         = 16;
  localparam int LVL_EXTRA       = 16;
  localparam int INT_W           = 40;
  localparam int OUT_W           = 24;
  localparam int PH_W            = PHASE_FRAC_BITS + 4;
  localparam int KMUL_W          = 18;
  localparam int K_SHIFT         = 24;
  localparam int KW_W            = 16;

  localparam logic [KMUL_W-1:0] K_008  = KMUL_W'(134218);
  localparam logic [KMUL_W-1:0] K_320  = KMUL_W'(52429);
  localparam logic [KMUL_W-1:0] K_0004 = KMUL_W'(6711);
  localparam logic [KW_W-1:0]   K_094  = KW_W'(61604);

  localparam logic signed [PH_W-1:0] PH_ONE = PH_W'(1) << PHASE_FRAC_BITS;
  localparam longint unsigned THR_VAL =
    ((64'd45 << PHASE_FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic signed [PH_W-1:0] PH_THR = PH_W'(THR_VAL);

  localparam logic [INT_W+KMUL_W-1:0] MULK_RND = (INT_W+KMUL_W)'(1) << (K_SHIFT - 1);

  typedef struct packed {
    logic signed [STEP_W-1:0]      phase_step;
    logic signed [SAMPLE_BITS-1:0] amplitude;
    logic [WIDTH_W-1:0]            pulse_width;
    logic                          hard_sync;
  } pod_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_out;
    logic                    sync_pulse;
  } pod_out_t;

  // When step_pend is set, slope holds the slope taken at the last edge and the
  // decay step derived from it has not yet been folded in.
  typedef struct packed {
    logic signed [PH_W-1:0]  phase;
    logic                    polarity_negative;
    logic                    trigger_latched;
    logic                    sync_level;
    logic signed [INT_W-1:0] level;
    logic signed [INT_W-1:0] slope;
    logic signed [INT_W-1:0] slope_step;
    logic                    step_pend;
  } pod_state_t;

  // Product with a Q0.24 constant, rounded to nearest with halves away from zero.
  function automatic logic signed [INT_W-1:0] mulk(input logic signed [INT_W-1:0] x,
                                                   input logic [KMUL_W-1:0] k);
    logic [INT_W-1:0]        mag;
    logic [INT_W+KMUL_W-1:0] prod;
    logic [INT_W-1:0]        r;
    mag  = x[INT_W-1] ? (~$unsigned(x) + 1'b1) : $unsigned(x);
    prod = {{KMUL_W{1'b0}}, mag} * {{INT_W{1'b0}}, k};
    r    = INT_W'((prod + MULK_RND) >> K_SHIFT);
    return x[INT_W-1] ? $signed(~r + 1'b1) : $signed(r);
  endfunction

  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [INT_W+1:0] x);
    if (x[INT_W+1:INT_W-1] == '0 || x[INT_W+1:INT_W-1] == '1) begin
      return x[INT_W-1:0];
    end else if (x[INT_W+1]) begin
      return {1'b1, {(INT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(INT_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: rtl/core/pod_step.sv
// Next-state and result logic for one oscillator sample.
`timescale 1ns / 1ps

module pod_step import pod_pkg::*; (
  input  pod_state_t st,
  input  pod_in_t    req,
  output pod_state_t nxt,
  output pod_out_t   res,
  output logic       res_valid
);

  localparam int INC_SHL = (PHASE_FRAC_BITS >= 24) ? PHASE_FRAC_BITS - 24 : 0;
  localparam int INC_SHR = (PHASE_FRAC_BITS < 24) ? 24 - PHASE_FRAC_BITS : 0;
  localparam int INC_W   = STEP_W + INC_SHL;
  localparam int OFF_SHR = 32 - PHASE_FRAC_BITS;

  logic [STEP_W-1:0]         mag;
  logic [INC_W-1:0]          inc_wide;
  logic signed [PH_W-1:0]    inc;
  logic signed [PH_W-1:0]    ph0;
  logic signed [PH_W-1:0]    ph1;
  logic signed [PH_W-1:0]    ph2;
  logic                      pol0;
  logic                      wrap;
  logic                      trig1;
  logic                      sync1;
  logic [WIDTH_W+KW_W-1:0]   off_prod;
  logic signed [PH_W-1:0]    off_ph;
  logic signed [INT_W-1:0]   amp_l;
  logic signed [INT_W-1:0]   ramp;
  logic signed [INT_W-1:0]   lvl_w;
  logic signed [INT_W-1:0]   slope0;
  logic signed [INT_W-1:0]   sc;
  logic signed [INT_W-1:0]   slope_t;
  logic signed [INT_W-1:0]   step_t;
  logic signed [INT_W-1:0]   slope_n;
  logic signed [INT_W-1:0]   level_new;

  always_comb begin
    mag      = req.phase_step[STEP_W-1] ? (~$unsigned(req.phase_step) + 1'b1)
                                        : $unsigned(req.phase_step);
    inc_wide = (INC_W'(mag) << INC_SHL) >> INC_SHR;
    inc      = $signed(PH_W'(inc_wide));

    ph0  = req.hard_sync ? PH_ONE : st.phase;
    pol0 = req.hard_sync ? 1'b0 : st.polarity_negative;
    ph1  = ph0 + inc;

    trig1 = st.trigger_latched;
    sync1 = st.sync_level;
    if (ph1 >= PH_THR && pol0) begin
      if (!st.trigger_latched) begin
        trig1 = 1'b1;
        sync1 = 1'b1;
      end else if (st.sync_level) begin
        sync1 = 1'b0;
      end
    end

    wrap     = ph1 >= PH_ONE;
    off_prod = {{KW_W{1'b0}}, req.pulse_width} * {{WIDTH_W{1'b0}}, K_094};
    off_ph   = $signed(PH_W'(off_prod >> OFF_SHR));
    ph2      = pol0 ? (ph1 - PH_ONE - off_ph) : (ph1 - PH_ONE + off_ph);

    amp_l = (INT_W'(req.amplitude)) <<< LVL_EXTRA;
    ramp  = mulk(amp_l, K_0004);

    lvl_w  = pol0 ? sat_int((INT_W+2)'(st.level) - (INT_W+2)'(amp_l)) : amp_l;
    slope0 = -mulk(lvl_w, K_008);

    sc      = -mulk(st.slope, K_320);
    slope_t = st.step_pend ? sat_int((INT_W+2)'(st.slope) + (INT_W+2)'(sc)) : st.slope;
    step_t  = st.step_pend ? sc : st.slope_step;
    slope_n = sat_int((INT_W+2)'(slope_t) + (INT_W+2)'(step_t));

    nxt                   = st;
    nxt.phase             = ph0;
    nxt.polarity_negative = pol0;
    res_valid             = 1'b0;
    level_new             = st.level;

    if (mag != '0) begin
      res_valid           = 1'b1;
      nxt.phase           = ph1;
      nxt.trigger_latched = trig1;
      nxt.sync_level      = sync1;
      if (wrap) begin
        // The decay step of a new edge is folded in on the following sample.
        // Its sign always follows the edge slope, so the clamp is decided now.
        level_new             = sat_int((INT_W+2)'(lvl_w) + (INT_W+2)'(slope0));
        nxt.phase             = ph2;
        nxt.trigger_latched   = 1'b0;
        nxt.polarity_negative = !pol0;
        if ((!pol0 && slope0 > 0) || (pol0 && slope0 < 0)) begin
          nxt.slope      = pol0 ? -ramp : ramp;
          nxt.slope_step = '0;
          nxt.step_pend  = 1'b0;
        end else begin
          nxt.slope      = slope0;
          nxt.step_pend  = 1'b1;
        end
      end else begin
        level_new     = sat_int((INT_W+2)'(st.level) + (INT_W+2)'(slope_t));
        nxt.step_pend = 1'b0;
        if ((pol0 && slope_n > 0) || (!pol0 && slope_n < 0)) begin
          nxt.slope      = pol0 ? ramp : -ramp;
          nxt.slope_step = '0;
        end else begin
          nxt.slope      = slope_n;
          nxt.slope_step = step_t;
        end
      end
      nxt.level = level_new;
    end

    res.sample_out = OUT_W'(level_new >>> LVL_EXTRA);
    res.sync_pulse = nxt.sync_level;
  end

endmodule

FILE: rtl/core/pulse_oscillator_with_droop.sv
// Top level of the pulse oscillator with sync output and droop.
// A request's result is registered in the output register, or in the skid register on a stall.
// Throughput: one request per clock while in_stall is low; the next state is combinational.
// A two-entry output stage (output register plus skid register) keeps input and output apart.
// Reset is synchronous and active low: phase returns to one, other state and valid flags clear.
// A request with zero phase step applies hard sync only and yields no result.
`timescale 1ns / 1ps

module pulse_oscillator_with_droop import pod_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pod_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pod_out_t out_data
);

  pod_state_t state_r;
  pod_state_t state_nxt;
  pod_state_t step_nxt;
  pod_out_t   res;
  logic       res_valid;
  logic       in_acc;
  logic       res_push;

  pod_out_t   out_data_r;
  pod_out_t   out_data_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  pod_out_t   skid_r;
  pod_out_t   skid_nxt;
  logic       skid_valid_r;
  logic       skid_valid_nxt;

  pod_step u_step (
    .st        (state_r),
    .req       (in_data),
    .nxt       (step_nxt),
    .res       (res),
    .res_valid (res_valid)
  );

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign res_push  = in_acc && res_valid;
  assign state_nxt = in_acc ? step_nxt : state_r;

  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt  = skid_valid_r || res_push;
      out_data_nxt   = skid_valid_r ? skid_r : res;
      skid_valid_nxt = 1'b0;
    end else if (res_push) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase             <= PH_ONE;
      state_r.polarity_negative <= 1'b0;
      state_r.trigger_latched   <= 1'b0;
      state_r.sync_level        <= 1'b0;
      state_r.level             <= '0;
      state_r.slope             <= '0;
      state_r.slope_step        <= '0;
      state_r.step_pend         <= 1'b0;
      out_valid_r               <= 1'b0;
      skid_valid_r              <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_silent_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !res_valid && !in_data.hard_sync) |=> $stable(state_r))
    else $error("a silent request changed the oscillator state");

  a_edge_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && step_nxt.step_pend) |=> out_valid_r)
    else $error("an edge request did not deliver a result");

endmodule

FILE: bench/pod_checker.sv
// Checker that predicts every oscillator sample from the accepted requests and compares it.
`timescale 1ns / 1ps

module pod_checker import pod_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  pod_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  pod_out_t out_data,
  output int       mismatch_count,
  output int       samples_outstanding
);

  localparam longint unsigned DROOP_START = 134218;
  localparam longint unsigned DROOP_DECAY = 52429;
  localparam longint unsigned DROOP_FLOOR = 6711;
  localparam longint unsigned WIDTH_GAIN  = 61604;
  localparam longint PHASE_UNIT = longint'(1) << PHASE_FRAC_BITS;
  localparam longint SYNC_POINT = ((longint'(45) << PHASE_FRAC_BITS) + 50) / 100;

  longint   osc_phase;
  logic     osc_negative;
  logic     osc_armed;
  logic     osc_sync;
  longint   osc_level;
  longint   osc_slope;
  longint   osc_slope_step;
  pod_out_t expected_samples[$];

  function automatic longint round_scale(input longint x, input longint unsigned k);
    longint unsigned mag;
    longint unsigned r;
    mag = (x < 0) ? -x : x;
    r = (mag * k + (64'd1 << 23)) >> 24;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp(input longint x, input int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (x > hi) return hi;
    if (x < -hi - 1) return -hi - 1;
    return x;
  endfunction

  function automatic longint wrap_phase(input longint x);
    logic signed [PH_W-1:0] t;
    t = x[PH_W-1:0];
    return longint'(t);
  endfunction

  task automatic advance_oscillator(input pod_in_t req);
    longint          step;
    longint          amp;
    longint          mag;
    longint          inc;
    longint          off;
    longint unsigned wid;
    pod_out_t        res;
    step = longint'(req.phase_step);
    amp  = longint'(req.amplitude) <<< LVL_EXTRA;
    wid  = longint'(req.pulse_width);
    if (req.hard_sync) begin
      osc_phase    = PHASE_UNIT;
      osc_negative = 1'b0;
    end
    mag = (step < 0) ? -step : step;
    if (mag == 0) return;
    inc = (PHASE_FRAC_BITS >= 24) ? (mag << (PHASE_FRAC_BITS - 24))
                                  : (mag >> (24 - PHASE_FRAC_BITS));
    osc_phase = wrap_phase(osc_phase + inc);

    if (osc_phase >= SYNC_POINT && osc_negative) begin
      if (!osc_armed) begin
        osc_armed = 1'b1;
        osc_sync  = 1'b1;
      end else if (osc_sync) begin
        osc_sync = 1'b0;
      end
    end

    if (osc_phase >= PHASE_UNIT) begin
      osc_armed = 1'b0;
      off = longint'((wid * WIDTH_GAIN) >> (32 - PHASE_FRAC_BITS));
      osc_phase = wrap_phase(osc_phase - PHASE_UNIT + (osc_negative ? -off : off));
      if (!osc_negative) begin
        osc_level = amp;
        osc_slope = -round_scale(amp, DROOP_START);
      end else begin
        osc_level = clamp(osc_level - amp, INT_W);
        osc_slope = -round_scale(osc_level, DROOP_START);
      end
      osc_slope_step = clamp(-round_scale(osc_slope, DROOP_DECAY), INT_W);
      osc_negative   = !osc_negative;
    end

    osc_level = clamp(osc_level + osc_slope, INT_W);
    osc_slope = clamp(osc_slope + osc_slope_step, INT_W);

    // Once the droop has decayed past zero it is held at a small residual slope.
    if (osc_negative && osc_slope > 0) begin
      osc_slope      = round_scale(amp, DROOP_FLOOR);
      osc_slope_step = 0;
    end else if (!osc_negative && osc_slope < 0) begin
      osc_slope      = -round_scale(amp, DROOP_FLOOR);
      osc_slope_step = 0;
    end

    res.sample_out = OUT_W'(clamp(osc_level >>> LVL_EXTRA, OUT_W));
    res.sync_pulse = osc_sync;
    expected_samples.push_back(res);
  endtask

  always @(posedge clk) begin : monitor
    pod_out_t want;
    if (!rst_n) begin
      osc_phase      = PHASE_UNIT;
      osc_negative   = 1'b0;
      osc_armed      = 1'b0;
      osc_sync       = 1'b0;
      osc_level      = 0;
      osc_slope      = 0;
      osc_slope_step = 0;
      mismatch_count = 0;
      expected_samples.delete();
    end else begin
      if (in_valid && !in_stall) begin
        advance_oscillator(in_data);
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, got %0d/%0b", $time,
                   out_data.sample_out, out_data.sync_pulse);
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            $display("%0t: sample_out expected %0d, got %0d", $time,
                     want.sample_out, out_data.sample_out);
            mismatch_count++;
          end
          if (out_data.sync_pulse !== want.sync_pulse) begin
            $display("%0t: sync_pulse expected %0b, got %0b", $time,
                     want.sync_pulse, out_data.sync_pulse);
            mismatch_count++;
          end
        end
      end
    end
    samples_outstanding = expected_samples.size();
  end

endmodule

FILE: bench/testbench.sv
// Testbench top: clock, reset, oscillator request stimulus, result stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
  import pod_pkg::*;

  localparam int STEP_MAX        = 8388608;
  localparam int RANDOM_REQUESTS = 1700;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pod_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pod_out_t out_data;
  int       mismatch_count;
  int       samples_outstanding;
  bit       send_idle = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pulse_oscillator_with_droop u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  pod_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data           (out_data),
    .mismatch_count     (mismatch_count),
    .samples_outstanding(samples_outstanding)
  );

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic pod_in_t make_request(input int step, input int amp, input int width,
                                           input bit sync);
    pod_in_t r;
    r.phase_step  = STEP_W'(step);
    r.amplitude   = SAMPLE_BITS'(amp);
    r.pulse_width = WIDTH_W'(width);
    r.hard_sync   = sync;
    return r;
  endfunction

  function automatic int random_step(input int max_mag);
    int m;
    m = $urandom_range(0, max_mag);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic send_request(input pod_in_t req);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : result_drain
    int hold;
    int served;
    bit idle;
    served = 0;
    idle   = 1'b1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (served % 48 == 0) idle = ($urandom_range(0, 3) != 0);
      hold = idle ? $urandom_range(0, 8) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      served++;
    end
  end

  initial begin : stimulus
    int sent;
    int run_len;
    int kind;
    int step;
    int amp;
    int width;
    bit sync;
    pod_in_t req;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 1'b1;
    send_request(make_request(STEP_MAX, 32767, 0, 1'b1));
    send_request(make_request(-STEP_MAX, -32768, 65535, 1'b0));
    send_request(make_request(STEP_MAX, 32767, 65535, 1'b0));
    send_request(make_request(0, 0, 0, 1'b1));
    send_request(make_request(0, -32768, 65535, 1'b0));
    send_request(make_request(1, 0, 32768, 1'b0));
    send_request(make_request(-1, 32767, 0, 1'b1));
    for (int i = 0; i < 18; i++) begin
      send_request(make_request(1677722, -32768, 65535, i == 0));
    end

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      kind      = $urandom_range(0, 39);
      send_idle = ($urandom_range(0, 3) != 0);
      amp       = $urandom_range(0, 65535);
      if ($urandom_range(0, 7) == 0) amp = $urandom_range(0, 1) ? 32767 : -32768;
      width = $urandom_range(0, 65535);
      if (kind < 4) begin
        run_len = $urandom_range(1, 10);
        for (int i = 0; i < run_len; i++) begin
          req = make_request(random_step(STEP_MAX), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
          send_request(req);
          if (req.phase_step != 0) sent++;
        end
      end else begin
        sync = 1'($urandom_range(0, 1));
        if (kind == 4) begin
          // A slow tone, started by a hard sync, lets the droop decay into its residual slope.
          step    = $urandom_range(30000, 50000);
          run_len = $urandom_range(340, 450);
          sync    = 1'b1;
        end else if (kind < 24) begin
          step    = $urandom_range(1, 1 << 20);
          run_len = $urandom_range(20, 80);
        end else begin
          step    = $urandom_range(1, STEP_MAX);
          run_len = $urandom_range(10, 50);
        end
        if ($urandom_range(0, 1)) step = -step;
        for (int i = 0; i < run_len; i++) begin
          req = make_request(($urandom_range(0, 29) == 0) ? 0 : step, amp, width,
                             (i == 0) && sync);
          send_request(req);
          if (req.phase_step != 0) sent++;
        end
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (samples_outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && samples_outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
